// ===== hdl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define RSI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, also checked during reset
`define RSI_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/rsi_pkg.sv =====
`timescale 1ns / 1ps

package rsi_pkg;

  localparam int TOL_W        = 48;
  localparam logic [TOL_W-1:0] TOL_RESET = 48'h0001_0000_0000;
  localparam int DEN_W        = 67;
  localparam int NUM_W        = 99;
  localparam int DIV_STEPS    = 32;
  localparam int FRONT_STAGES = 7;
  localparam int BACK_STAGES  = 5;

  typedef struct packed {
    logic              kind;
    logic signed [31:0] first_start_x;
    logic signed [31:0] first_start_y;
    logic signed [31:0] first_end_x;
    logic signed [31:0] first_end_y;
    logic signed [31:0] second_start_x;
    logic signed [31:0] second_start_y;
    logic signed [31:0] second_end_x;
    logic signed [31:0] second_end_y;
  } in_word_t;

  typedef struct packed {
    logic              hit;
    logic              parallel;
    logic              overflow;
    logic signed [31:0] cross_x;
    logic signed [31:0] cross_y;
  } out_word_t;

  typedef struct packed {
    in_word_t         geo;
    logic             parallel;
    logic [DEN_W-1:0] dabs;
    logic             neg_x;
    logic             neg_y;
    logic             big_x;
    logic             big_y;
    logic [DEN_W-1:0] rem_x;
    logic [DEN_W-1:0] rem_y;
    logic [31:0]      w_x;
    logic [31:0]      w_y;
  } div_word_t;

  function automatic logic signed [32:0] sx33(logic signed [31:0] a);
    return {a[31], a};
  endfunction

  function automatic logic signed [32:0] sub33(logic signed [31:0] a, logic signed [31:0] b);
    return sx33(a) - sx33(b);
  endfunction

  function automatic logic signed [63:0] mul32(logic signed [31:0] a, logic signed [31:0] b);
    return a * b;
  endfunction

  function automatic logic signed [65:0] mul33(logic signed [32:0] a, logic signed [32:0] b);
    return a * b;
  endfunction

endpackage

// ===== hdl/ray_segment_intersection_core.sv =====
`timescale 1ns / 1ps
// ray or segment against segment intersection, Q16.16 coordinates
// item channel (item_valid / item_ready / item): one word holds both lines and
//   the kind bit; a word is taken when valid and ready are high at a clock edge
// result channel (result_valid / result_ready / result): hit, parallel,
//   overflow and the saturated crossing point, one result word per item word
// cfg channel (cfg_valid / cfg_ready / cfg_data): writes the 48-bit collinearity
//   tolerance, Q16.32; always ready; write only while no item is in flight
// stages: the 7 front stages of products and sums, the 32 stages of the
//   bit-per-stage divider and the 5 stages of saturation and line tests
// throughput: one item per cycle when not stalled, each stage has a valid bit
// reset (rst, synchronous): empties every stage, tolerance returns to 1.0
// receiver stall: the result word holds; stages behind it keep filling
//   empty slots and item_ready drops only once every stage is occupied

module ray_segment_intersection_core import rsi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  in_word_t         item,
  output logic             result_valid,
  input  logic             result_ready,
  output out_word_t        result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [TOL_W-1:0] cfg_data
);

  logic [TOL_W-1:0] tol;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg_valid) begin
      tol <= cfg_data;
    end
  end

  logic [DIV_STEPS:0] dv, dr;
  div_word_t          dw [DIV_STEPS+1];

  rsi_front u_front (
    .clk      (clk),
    .rst      (rst),
    .up_valid (item_valid),
    .up_ready (item_ready),
    .up_word  (item),
    .dn_valid (dv[0]),
    .dn_ready (dr[0]),
    .dn_word  (dw[0])
  );

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    rsi_div_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (dv[g]),
      .up_ready (dr[g]),
      .up_word  (dw[g]),
      .dn_valid (dv[g+1]),
      .dn_ready (dr[g+1]),
      .dn_word  (dw[g+1])
    );
  end

  rsi_back u_back (
    .clk      (clk),
    .rst      (rst),
    .tol      (tol),
    .up_valid (dv[DIV_STEPS]),
    .up_ready (dr[DIV_STEPS]),
    .up_word  (dw[DIV_STEPS]),
    .dn_valid (result_valid),
    .dn_ready (result_ready),
    .dn_word  (result)
  );

endmodule

// ===== hdl/rsi_front.sv =====
`timescale 1ns / 1ps

module rsi_front import rsi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      up_valid,
  output logic      up_ready,
  input  in_word_t  up_word,
  output logic      dn_valid,
  input  logic      dn_ready,
  output div_word_t dn_word
);

  logic [FRONT_STAGES-1:0] v;
  logic [FRONT_STAGES:0]   adv;

  always_comb begin
    adv[FRONT_STAGES] = dn_ready;
    for (int k = FRONT_STAGES - 1; k >= 0; k--) begin
      adv[k] = ~v[k] | adv[k+1];
    end
  end

  assign up_ready = adv[0];
  assign dn_valid = v[FRONT_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= up_valid;
      end
      for (int k = 1; k < FRONT_STAGES; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // stage 1: differences and cross terms
  in_word_t           geo1;
  logic signed [32:0] dx12_1, dy12_1, dx34_1, dy34_1;
  logic signed [63:0] pa_1, pb_1, pc_1, pd_1;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      geo1   <= up_word;
      dx12_1 <= sub33(up_word.first_start_x, up_word.first_end_x);
      dy12_1 <= sub33(up_word.first_start_y, up_word.first_end_y);
      dx34_1 <= sub33(up_word.second_start_x, up_word.second_end_x);
      dy34_1 <= sub33(up_word.second_start_y, up_word.second_end_y);
      pa_1   <= mul32(up_word.first_start_x, up_word.first_end_y);
      pb_1   <= mul32(up_word.first_end_x, up_word.first_start_y);
      pc_1   <= mul32(up_word.second_start_x, up_word.second_end_y);
      pd_1   <= mul32(up_word.second_end_x, up_word.second_start_y);
    end
  end

  // stage 2: denominator products, c1 and c2
  in_word_t           geo2;
  logic signed [32:0] dx12_2, dy12_2, dx34_2, dy34_2;
  logic signed [65:0] m1_2, m2_2;
  logic signed [64:0] c1_2, c2_2;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      geo2   <= geo1;
      dx12_2 <= dx12_1;
      dy12_2 <= dy12_1;
      dx34_2 <= dx34_1;
      dy34_2 <= dy34_1;
      m1_2   <= mul33(dx12_1, dy34_1);
      m2_2   <= mul33(dy12_1, dx34_1);
      c1_2   <= 65'(pa_1) - 65'(pb_1);
      c2_2   <= 65'(pc_1) - 65'(pd_1);
    end
  end

  // stage 3: denominator, numerator partial products
  in_word_t           geo3;
  logic signed [DEN_W-1:0] den_3;
  logic signed [65:0] c1x_lo, c1x_hi, c2x_lo, c2x_hi;
  logic signed [65:0] c1y_lo, c1y_hi, c2y_lo, c2y_hi;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      geo3   <= geo2;
      den_3  <= DEN_W'(m1_2) - DEN_W'(m2_2);
      c1x_lo <= mul33($signed({1'b0, c1_2[31:0]}), dx34_2);
      c1x_hi <= mul33($signed(c1_2[64:32]), dx34_2);
      c2x_lo <= mul33($signed({1'b0, c2_2[31:0]}), dx12_2);
      c2x_hi <= mul33($signed(c2_2[64:32]), dx12_2);
      c1y_lo <= mul33($signed({1'b0, c1_2[31:0]}), dy34_2);
      c1y_hi <= mul33($signed(c1_2[64:32]), dy34_2);
      c2y_lo <= mul33($signed({1'b0, c2_2[31:0]}), dy12_2);
      c2y_hi <= mul33($signed(c2_2[64:32]), dy12_2);
    end
  end

  // stage 4: partial product sums, denominator magnitude
  in_word_t                geo4;
  logic signed [NUM_W-1:0] t1x_4, t2x_4, t1y_4, t2y_4;
  logic [DEN_W-1:0]        dabs_4;
  logic                    dneg_4, dzero_4;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      geo4    <= geo3;
      t1x_4   <= (NUM_W'(c1x_hi) <<< 32) + NUM_W'(c1x_lo);
      t2x_4   <= (NUM_W'(c2x_hi) <<< 32) + NUM_W'(c2x_lo);
      t1y_4   <= (NUM_W'(c1y_hi) <<< 32) + NUM_W'(c1y_lo);
      t2y_4   <= (NUM_W'(c2y_hi) <<< 32) + NUM_W'(c2y_lo);
      dabs_4  <= den_3[DEN_W-1] ? DEN_W'(-den_3) : DEN_W'(den_3);
      dneg_4  <= den_3[DEN_W-1];
      dzero_4 <= (den_3 == '0);
    end
  end

  // stage 5: numerators
  in_word_t                geo5;
  logic signed [NUM_W-1:0] nx_5, ny_5;
  logic [DEN_W-1:0]        dabs_5;
  logic                    dneg_5, dzero_5;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      geo5    <= geo4;
      nx_5    <= t1x_4 - t2x_4;
      ny_5    <= t1y_4 - t2y_4;
      dabs_5  <= dabs_4;
      dneg_5  <= dneg_4;
      dzero_5 <= dzero_4;
    end
  end

  // stage 6: numerator magnitudes and quotient signs
  in_word_t         geo6;
  logic [NUM_W-1:0] nax_6, nay_6;
  logic [DEN_W-1:0] dabs_6;
  logic             negx_6, negy_6, dzero_6;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      geo6    <= geo5;
      nax_6   <= nx_5[NUM_W-1] ? NUM_W'(-nx_5) : NUM_W'(nx_5);
      nay_6   <= ny_5[NUM_W-1] ? NUM_W'(-ny_5) : NUM_W'(ny_5);
      negx_6  <= nx_5[NUM_W-1] ^ dneg_5;
      negy_6  <= ny_5[NUM_W-1] ^ dneg_5;
      dabs_6  <= dabs_5;
      dzero_6 <= dzero_5;
    end
  end

  // stage 7: quotient range check, divider setup
  always_ff @(posedge clk) begin
    if (adv[6]) begin
      dn_word.geo      <= geo6;
      dn_word.parallel <= dzero_6;
      dn_word.dabs     <= dabs_6;
      dn_word.neg_x    <= negx_6;
      dn_word.neg_y    <= negy_6;
      dn_word.big_x    <= (nax_6[NUM_W-1:32] >= dabs_6);
      dn_word.big_y    <= (nay_6[NUM_W-1:32] >= dabs_6);
      dn_word.rem_x    <= nax_6[NUM_W-1:32];
      dn_word.rem_y    <= nay_6[NUM_W-1:32];
      dn_word.w_x      <= nax_6[31:0];
      dn_word.w_y      <= nay_6[31:0];
    end
  end

endmodule

// ===== hdl/rsi_div_stage.sv =====
`timescale 1ns / 1ps

module rsi_div_stage import rsi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      up_valid,
  output logic      up_ready,
  input  div_word_t up_word,
  output logic      dn_valid,
  input  logic      dn_ready,
  output div_word_t dn_word
);

  logic [DEN_W:0] rx2, ry2, dext;
  logic           gex, gey;
  div_word_t      nxt;

  assign up_ready = ~dn_valid | dn_ready;

  // one restoring quotient bit for each coordinate
  always_comb begin
    dext      = {1'b0, up_word.dabs};
    rx2       = {up_word.rem_x, up_word.w_x[31]};
    ry2       = {up_word.rem_y, up_word.w_y[31]};
    gex       = (rx2 >= dext);
    gey       = (ry2 >= dext);
    nxt       = up_word;
    nxt.rem_x = gex ? DEN_W'(rx2 - dext) : rx2[DEN_W-1:0];
    nxt.rem_y = gey ? DEN_W'(ry2 - dext) : ry2[DEN_W-1:0];
    nxt.w_x   = {up_word.w_x[30:0], gex};
    nxt.w_y   = {up_word.w_y[30:0], gey};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dn_word <= nxt;
    end
  end

endmodule

// ===== hdl/rsi_back.sv =====
`timescale 1ns / 1ps

module rsi_back import rsi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [TOL_W-1:0] tol,
  input  logic             up_valid,
  output logic             up_ready,
  input  div_word_t        up_word,
  output logic             dn_valid,
  input  logic             dn_ready,
  output out_word_t        dn_word
);

  typedef struct packed {
    logic signed [32:0] ab_y;
    logic signed [32:0] bp_y;
    logic signed [32:0] pa_y;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] pa_x;
  } line_diff_t;

  typedef struct packed {
    logic signed [65:0] t0;
    logic signed [65:0] t1;
    logic signed [65:0] t2;
    logic signed [65:0] q0;
    logic signed [65:0] q1;
    logic signed [65:0] s0;
    logic signed [65:0] s1;
  } line_prod_t;

  typedef struct packed {
    logic signed [67:0] det;
    logic signed [67:0] dot;
    logic signed [67:0] len2;
  } line_sum_t;

  function automatic line_diff_t diffs(logic signed [31:0] px, logic signed [31:0] py,
                                       logic signed [31:0] ax, logic signed [31:0] ay,
                                       logic signed [31:0] bx, logic signed [31:0] by);
    line_diff_t r;
    r.ab_y = sub33(ay, by);
    r.bp_y = sub33(by, py);
    r.pa_y = sub33(py, ay);
    r.dx   = sub33(bx, ax);
    r.dy   = sub33(by, ay);
    r.pa_x = sub33(px, ax);
    return r;
  endfunction

  function automatic line_prod_t prods(logic signed [31:0] px, logic signed [31:0] ax,
                                       logic signed [31:0] bx, line_diff_t d);
    line_prod_t r;
    r.t0 = mul33(sx33(px), d.ab_y);
    r.t1 = mul33(sx33(ax), d.bp_y);
    r.t2 = mul33(sx33(bx), d.pa_y);
    r.q0 = mul33(d.dx, d.pa_x);
    r.q1 = mul33(d.dy, d.pa_y);
    r.s0 = mul33(d.dx, d.dx);
    r.s1 = mul33(d.dy, d.dy);
    return r;
  endfunction

  function automatic line_sum_t sums(line_prod_t p);
    line_sum_t r;
    r.det  = 68'(p.t0) + 68'(p.t1) + 68'(p.t2);
    r.dot  = 68'(p.q0) + 68'(p.q1);
    r.len2 = 68'(p.s0) + 68'(p.s1);
    return r;
  endfunction

  function automatic logic passes(line_sum_t s, logic seg, logic signed [67:0] t);
    logic col;
    col = (s.det < t) && (s.det > -t);
    return col && (s.dot > 68'sd0) && (!seg || !(s.len2 < s.dot));
  endfunction

  logic [BACK_STAGES-1:0] v;
  logic [BACK_STAGES:0]   adv;

  always_comb begin
    adv[BACK_STAGES] = dn_ready;
    for (int k = BACK_STAGES - 1; k >= 0; k--) begin
      adv[k] = ~v[k] | adv[k+1];
    end
  end

  assign up_ready = adv[0];
  assign dn_valid = v[BACK_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= up_valid;
      end
      for (int k = 1; k < BACK_STAGES; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // stage 1: saturation and sign
  logic [31:0] lim_x, lim_y, qs_x, qs_y;
  logic        ov_x, ov_y;

  always_comb begin
    lim_x = up_word.neg_x ? 32'h8000_0000 : 32'h7fff_ffff;
    lim_y = up_word.neg_y ? 32'h8000_0000 : 32'h7fff_ffff;
    ov_x  = up_word.big_x | (up_word.w_x > lim_x);
    ov_y  = up_word.big_y | (up_word.w_y > lim_y);
    qs_x  = ov_x ? lim_x : up_word.w_x;
    qs_y  = ov_y ? lim_y : up_word.w_y;
  end

  in_word_t           geo1;
  logic signed [31:0] px1, py1;
  logic               ovf1, par1;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      geo1 <= up_word.geo;
      px1  <= up_word.neg_x ? $signed(-qs_x) : $signed(qs_x);
      py1  <= up_word.neg_y ? $signed(-qs_y) : $signed(qs_y);
      ovf1 <= ov_x | ov_y;
      par1 <= up_word.parallel;
    end
  end

  // stage 2: differences against both lines
  in_word_t           geo2;
  logic signed [31:0] px2, py2;
  logic               ovf2, par2;
  line_diff_t         da2, db2;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      geo2 <= geo1;
      px2  <= px1;
      py2  <= py1;
      ovf2 <= ovf1;
      par2 <= par1;
      da2  <= diffs(px1, py1, geo1.first_start_x, geo1.first_start_y,
                    geo1.first_end_x, geo1.first_end_y);
      db2  <= diffs(px1, py1, geo1.second_start_x, geo1.second_start_y,
                    geo1.second_end_x, geo1.second_end_y);
    end
  end

  // stage 3: products
  logic               kind3, ovf3, par3;
  logic signed [31:0] px3, py3;
  line_prod_t         pa3, pb3;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      kind3 <= geo2.kind;
      ovf3  <= ovf2;
      par3  <= par2;
      px3   <= px2;
      py3   <= py2;
      pa3   <= prods(px2, geo2.first_start_x, geo2.first_end_x, da2);
      pb3   <= prods(px2, geo2.second_start_x, geo2.second_end_x, db2);
    end
  end

  // stage 4: determinant, projection, squared length
  logic               kind4, ovf4, par4;
  logic signed [31:0] px4, py4;
  line_sum_t          sa4, sb4;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      kind4 <= kind3;
      ovf4  <= ovf3;
      par4  <= par3;
      px4   <= px3;
      py4   <= py3;
      sa4   <= sums(pa3);
      sb4   <= sums(pb3);
    end
  end

  // stage 5: line tests and result word
  logic signed [67:0] tol_s;
  logic               hit5;

  assign tol_s = $signed({20'b0, tol});
  assign hit5  = passes(sa4, kind4, tol_s) && passes(sb4, 1'b1, tol_s);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      if (par4) begin
        dn_word <= '{hit: 1'b0, parallel: 1'b1, overflow: 1'b0, cross_x: '0, cross_y: '0};
      end else begin
        dn_word <= '{hit: hit5, parallel: 1'b0, overflow: ovf4, cross_x: px4, cross_y: py4};
      end
    end
  end

endmodule

// ===== hdl/rsi_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rsi_checker import rsi_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input in_word_t         item,
  input logic             result_valid,
  input logic             result_ready,
  input out_word_t        result
);

  `RSI_ASSERT_RST(a_reset_empty, rst |=> !result_valid, "result valid right after reset")

  `RSI_ASSERT(a_item_hold, item_valid && !item_ready |=> item_valid && $stable(item), "waiting item word changed")

  `RSI_ASSERT(a_stall_hold, result_valid && !result_ready |=> result_valid && $stable(result), "stalled result word changed")

  `RSI_ASSERT(a_parallel_clean, result_valid && result.parallel |-> !result.hit && !result.overflow && result.cross_x == 0 && result.cross_y == 0, "parallel word carries a point")

  `RSI_ASSERT(a_overflow_bound, result_valid && result.overflow |-> result.cross_x == 32'h7fff_ffff || result.cross_x == 32'h8000_0000 || result.cross_y == 32'h7fff_ffff || result.cross_y == 32'h8000_0000, "overflow without a saturated coordinate")

endmodule

bind ray_segment_intersection_core rsi_checker u_rsi_checker (.*);
